### hdl/nnrs_pkg.sv
// shared types, constants and helpers for the nearest neighbor rgb565 scaler
// used by nnrs_div and nearest_neighbor_rgb565_scaler; no dependencies
package nnrs_pkg;

    // size limits
    localparam int unsigned MAX_DIM       = 2048;
    localparam int unsigned MAX_SCALE_DEF = 8;
    localparam int unsigned COUNT_SPAN    = 2048;

    // datapath widths
    localparam int unsigned DIM_W  = 12;             // register and tile sizes
    localparam int unsigned POS_W  = 11;             // tile column and row
    localparam int unsigned NUM_W  = 2 * DIM_W + 1;  // i*t + s - 1
    localparam int unsigned CNT_W  = $clog2(DIM_W);  // divider step count
    localparam int unsigned IDX_W  = 22;
    localparam int unsigned PIX_W  = 16;
    localparam int unsigned CFG_AW = 2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SRC_W = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SRC_H = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DST_W = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_DST_H = 2'd3;

    // position memory entries
    localparam logic POS_COL = 1'b0;
    localparam logic POS_ROW = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_COL,
        S_LOAD_ROW,
        S_STORE_ROW,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SPAN,
        S_ROW,
        S_EMIT
    } t_state;

    // zero acts as one, anything above hi acts as hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > int'(hi)) begin
            res = DIM_W'(hi);
        end
        return res;
    endfunction

endpackage

### hdl/nnrs_div.sv
// restoring divider, one quotient bit per cycle, for the span bounds
// depends on nnrs_pkg; quotient must fit in DIM_W bits (numerator < den << DIM_W)
module nnrs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nnrs_pkg::NUM_W-1:0]    i_num,
    input  logic [nnrs_pkg::DIM_W-1:0]    i_den,
    output logic                          o_done,
    output logic [nnrs_pkg::DIM_W-1:0]    o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [nnrs_pkg::CNT_W-1:0]    r_cnt;
    logic [nnrs_pkg::DIM_W-1:0]    r_rem;
    logic [nnrs_pkg::DIM_W-1:0]    r_dq;

    logic [nnrs_pkg::DIM_W:0]      shifted;
    logic [nnrs_pkg::DIM_W+1:0]    diff;
    logic                          take;
    logic                          last_step;

    assign shifted   = {r_rem, r_dq[nnrs_pkg::DIM_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, i_den};
    assign take      = !diff[nnrs_pkg::DIM_W+1];
    assign last_step = (r_cnt == nnrs_pkg::CNT_W'(nnrs_pkg::DIM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and numerator bits share a shift pair, quotient enters from the right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= i_num[2*nnrs_pkg::DIM_W-1:nnrs_pkg::DIM_W];
            r_dq  <= i_num[nnrs_pkg::DIM_W-1:0];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= take ? diff[nnrs_pkg::DIM_W-1:0] : shifted[nnrs_pkg::DIM_W-1:0];
            r_dq  <= {r_dq[nnrs_pkg::DIM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

### hdl/nearest_neighbor_rgb565_scaler.sv
// Nearest neighbor scaler for RGB565 tiles: one source pixel in, up to MAX_SCALE squared
// destination writes out, last write marked. Works on one word at a time. A word whose
// source position falls outside the image returns to idle once the position memory is
// written back. Otherwise the four span bounds ceil(i*T/S) go one after another through a
// shared bit-serial divider, then come cy rows of cx writes, cx and cy being the
// replication counts, or no writes when either span is empty. The tile
// column and row live in a two-entry position memory read and written back once per word.
// The output register lets a finished write wait while the block moves on.
// Depends on nnrs_pkg and nnrs_div.
module nearest_neighbor_rgb565_scaler #(
    parameter int unsigned MAX_SCALE = nnrs_pkg::MAX_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [nnrs_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [nnrs_pkg::DIM_W-1:0]     i_cfg_data,
    // source pixels
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [nnrs_pkg::DIM_W-1:0]     i_tile_x,
    input  logic [nnrs_pkg::DIM_W-1:0]     i_tile_y,
    input  logic [nnrs_pkg::DIM_W-1:0]     i_tile_width,
    input  logic [nnrs_pkg::DIM_W-1:0]     i_tile_height,
    input  logic [nnrs_pkg::PIX_W-1:0]     i_pixel_value,
    // destination writes
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [nnrs_pkg::POS_W-1:0]     o_dest_x,
    output logic [nnrs_pkg::POS_W-1:0]     o_dest_y,
    output logic [nnrs_pkg::IDX_W-1:0]     o_dest_index,
    output logic [nnrs_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                           o_last_write
);

    localparam int unsigned DW    = nnrs_pkg::DIM_W;
    localparam int unsigned PW    = nnrs_pkg::POS_W;
    localparam int unsigned NW    = nnrs_pkg::NUM_W;
    localparam int unsigned SpanW = (MAX_SCALE < 2) ? 1 : $clog2(MAX_SCALE + 1);

    // control registers
    nnrs_pkg::t_state    r_state, n_state;
    logic [1:0]          r_k, n_k;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_pos_vld;
    logic [DW-1:0]       r_src_w, r_src_h, r_dst_w, r_dst_h;

    // work registers
    logic [DW-1:0]       r_tile_x, n_tile_x, r_tile_y, n_tile_y;
    logic [DW-1:0]       r_tile_w, n_tile_w, r_tile_h, n_tile_h;
    logic [nnrs_pkg::PIX_W-1:0] r_pix, n_pix;
    logic [PW-1:0]       r_col, n_col, r_next_row, n_next_row;
    logic                r_hit, n_hit;
    logic [DW-1:0]       r_ax, n_ax, r_ay, n_ay;
    logic [NW-1:0]       r_num, n_num;
    logic [DW-1:0]       r_x1, n_x1, r_x2, n_x2, r_y1, n_y1, r_y2, n_y2;
    logic [SpanW-1:0]    r_cx, n_cx, r_cy, n_cy, r_c, n_c, r_r, n_r;
    logic [DW:0]         r_dy, n_dy;
    logic [nnrs_pkg::IDX_W-1:0] r_row_base, n_row_base;

    // output register
    logic [PW-1:0]       r_dest_x, n_dest_x, r_dest_y, n_dest_y;
    logic [nnrs_pkg::IDX_W-1:0] r_dest_index, n_dest_index;
    logic [nnrs_pkg::PIX_W-1:0] r_pix_out, n_pix_out;
    logic                r_last, n_last;

    // position memory: column and tile row
    logic [PW-1:0]       r_pos_mem [0:1];
    logic [PW-1:0]       r_rdata;
    logic                r_rdata_ok;
    logic                mem_we;
    logic                mem_waddr;
    logic [PW-1:0]       mem_wdata;
    logic                mem_raddr;
    logic [PW-1:0]       pos_rd;

    // clamped sizes
    logic [DW-1:0]       sw, sh, tw, th;

    // datapath
    logic [DW+1:0]       ax_full, ay_full;
    logic [DW-1:0]       col_inc, row_inc;
    logic [DW-1:0]       mul_i, mul_t, mul_s;
    logic [NW-1:0]       num_val;
    logic [DW-1:0]       dxd, dyd;
    logic [SpanW-1:0]    cx_sat, cy_sat;
    logic [DW:0]         dx, dy_new;
    logic [NW-1:0]       prod_row;
    logic                load_out;
    logic                div_start, div_done;
    logic [DW-1:0]       div_quot;

    assign sw = nnrs_pkg::clamp_dim(r_src_w, nnrs_pkg::MAX_DIM);
    assign sh = nnrs_pkg::clamp_dim(r_src_h, nnrs_pkg::MAX_DIM);
    assign tw = nnrs_pkg::clamp_dim(r_dst_w, nnrs_pkg::MAX_DIM);
    assign th = nnrs_pkg::clamp_dim(r_dst_h, nnrs_pkg::MAX_DIM);

    assign pos_rd = r_rdata_ok ? r_rdata : '0;

    // absolute source position, signed
    assign ax_full = {{2{r_tile_x[DW-1]}}, r_tile_x} + (DW+2)'(r_col);
    assign ay_full = {{2{r_tile_y[DW-1]}}, r_tile_y} + (DW+2)'(pos_rd);

    assign col_inc = DW'(r_col) + DW'(1);
    assign row_inc = DW'(pos_rd) + DW'(1);

    // operands of the span bound being worked on: x or y axis, start or end
    assign mul_i   = r_k[1] ? (r_k[0] ? r_ay + DW'(1) : r_ay)
                            : (r_k[0] ? r_ax + DW'(1) : r_ax);
    assign mul_t   = r_k[1] ? th : tw;
    assign mul_s   = r_k[1] ? sh : sw;
    assign num_val = NW'(mul_i) * NW'(mul_t) + NW'(mul_s) - NW'(1);

    assign dxd = (r_x2 > r_x1) ? r_x2 - r_x1 : '0;
    assign dyd = (r_y2 > r_y1) ? r_y2 - r_y1 : '0;
    assign cx_sat = (int'(dxd) > int'(MAX_SCALE)) ? SpanW'(MAX_SCALE) : dxd[SpanW-1:0];
    assign cy_sat = (int'(dyd) > int'(MAX_SCALE)) ? SpanW'(MAX_SCALE) : dyd[SpanW-1:0];

    assign dx       = {1'b0, r_x1} + (DW+1)'(r_c);
    assign dy_new   = {1'b0, r_y1} + (DW+1)'(r_r);
    assign prod_row = NW'(dy_new) * NW'(tw);

    assign load_out  = (r_state == nnrs_pkg::S_EMIT) && (!r_out_valid || i_ready);
    assign div_start = (r_state == nnrs_pkg::S_DIV_GO);

    nnrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (mul_s),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_tile_x     = r_tile_x;
        n_tile_y     = r_tile_y;
        n_tile_w     = r_tile_w;
        n_tile_h     = r_tile_h;
        n_pix        = r_pix;
        n_col        = r_col;
        n_next_row   = r_next_row;
        n_hit        = r_hit;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_num        = r_num;
        n_x1         = r_x1;
        n_x2         = r_x2;
        n_y1         = r_y1;
        n_y2         = r_y2;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_c          = r_c;
        n_r          = r_r;
        n_dy         = r_dy;
        n_row_base   = r_row_base;
        n_dest_x     = r_dest_x;
        n_dest_y     = r_dest_y;
        n_dest_index = r_dest_index;
        n_pix_out    = r_pix_out;
        n_last       = r_last;
        n_out_valid  = i_ready ? 1'b0 : r_out_valid;
        mem_we       = 1'b0;
        mem_waddr    = nnrs_pkg::POS_COL;
        mem_wdata    = '0;
        mem_raddr    = nnrs_pkg::POS_COL;
        o_ready      = (r_state == nnrs_pkg::S_IDLE);

        case (r_state)
            nnrs_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_tile_x = i_tile_x;
                    n_tile_y = i_tile_y;
                    n_tile_w = nnrs_pkg::clamp_dim(i_tile_width, nnrs_pkg::COUNT_SPAN);
                    n_tile_h = nnrs_pkg::clamp_dim(i_tile_height, nnrs_pkg::COUNT_SPAN);
                    n_pix    = i_pixel_value;
                    n_state  = nnrs_pkg::S_LOAD_COL;
                end
            end
            nnrs_pkg::S_LOAD_COL: begin
                n_col     = pos_rd;
                mem_raddr = nnrs_pkg::POS_ROW;
                n_state   = nnrs_pkg::S_LOAD_ROW;
            end
            nnrs_pkg::S_LOAD_ROW: begin
                n_hit = !ax_full[DW+1] && !ay_full[DW+1]
                        && (ax_full[DW:0] < {1'b0, sw}) && (ay_full[DW:0] < {1'b0, sh});
                n_ax  = ax_full[DW-1:0];
                n_ay  = ay_full[DW-1:0];
                // advance within the tile, write the column back now and the row next cycle
                mem_we    = 1'b1;
                mem_waddr = nnrs_pkg::POS_COL;
                if (col_inc >= r_tile_w) begin
                    mem_wdata  = '0;
                    n_next_row = (row_inc >= r_tile_h) ? '0 : row_inc[PW-1:0];
                end else begin
                    mem_wdata  = col_inc[PW-1:0];
                    n_next_row = pos_rd;
                end
                n_state = nnrs_pkg::S_STORE_ROW;
            end
            nnrs_pkg::S_STORE_ROW: begin
                mem_we    = 1'b1;
                mem_waddr = nnrs_pkg::POS_ROW;
                mem_wdata = r_next_row;
                n_k       = 2'd0;
                n_state   = r_hit ? nnrs_pkg::S_MUL : nnrs_pkg::S_IDLE;
            end
            nnrs_pkg::S_MUL: begin
                n_num   = num_val;
                n_state = nnrs_pkg::S_DIV_GO;
            end
            nnrs_pkg::S_DIV_GO: begin
                n_state = nnrs_pkg::S_DIV_WAIT;
            end
            nnrs_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    if (!r_k[1]) begin
                        if (!r_k[0]) n_x1 = div_quot;
                        else         n_x2 = div_quot;
                    end else begin
                        if (!r_k[0]) n_y1 = div_quot;
                        else         n_y2 = div_quot;
                    end
                    n_k     = r_k + 2'd1;
                    n_state = (r_k == 2'd3) ? nnrs_pkg::S_SPAN : nnrs_pkg::S_MUL;
                end
            end
            nnrs_pkg::S_SPAN: begin
                n_cx = cx_sat;
                n_cy = cy_sat;
                n_c  = '0;
                n_r  = '0;
                // an empty span on either axis gives no writes
                n_state = (cx_sat == '0 || cy_sat == '0) ? nnrs_pkg::S_IDLE : nnrs_pkg::S_ROW;
            end
            nnrs_pkg::S_ROW: begin
                n_dy       = dy_new;
                n_row_base = prod_row[nnrs_pkg::IDX_W-1:0];
                n_state    = nnrs_pkg::S_EMIT;
            end
            nnrs_pkg::S_EMIT: begin
                if (load_out) begin
                    n_out_valid  = 1'b1;
                    n_dest_x     = dx[PW-1:0];
                    n_dest_y     = r_dy[PW-1:0];
                    n_dest_index = r_row_base + nnrs_pkg::IDX_W'(dx);
                    n_pix_out    = r_pix;
                    n_last       = (r_c == r_cx - SpanW'(1)) && (r_r == r_cy - SpanW'(1));
                    if (r_c == r_cx - SpanW'(1)) begin
                        n_c = '0;
                        if (r_r == r_cy - SpanW'(1)) begin
                            n_state = nnrs_pkg::S_IDLE;
                        end else begin
                            n_r     = r_r + SpanW'(1);
                            n_state = nnrs_pkg::S_ROW;
                        end
                    end else begin
                        n_c = r_c + SpanW'(1);
                    end
                end
            end
            default: begin
                n_state = nnrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nnrs_pkg::S_IDLE;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
            r_pos_vld   <= 2'b00;
            r_src_w     <= DW'(1);
            r_src_h     <= DW'(1);
            r_dst_w     <= DW'(1);
            r_dst_h     <= DW'(1);
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (mem_we) begin
                r_pos_vld[mem_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nnrs_pkg::CFG_SRC_W: r_src_w <= i_cfg_data;
                    nnrs_pkg::CFG_SRC_H: r_src_h <= i_cfg_data;
                    nnrs_pkg::CFG_DST_W: r_dst_w <= i_cfg_data;
                    nnrs_pkg::CFG_DST_H: r_dst_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // position memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pos_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata    <= r_pos_mem[mem_raddr];
        r_rdata_ok <= r_pos_vld[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_tile_x     <= n_tile_x;
        r_tile_y     <= n_tile_y;
        r_tile_w     <= n_tile_w;
        r_tile_h     <= n_tile_h;
        r_pix        <= n_pix;
        r_col        <= n_col;
        r_next_row   <= n_next_row;
        r_hit        <= n_hit;
        r_ax         <= n_ax;
        r_ay         <= n_ay;
        r_num        <= n_num;
        r_x1         <= n_x1;
        r_x2         <= n_x2;
        r_y1         <= n_y1;
        r_y2         <= n_y2;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_c          <= n_c;
        r_r          <= n_r;
        r_dy         <= n_dy;
        r_row_base   <= n_row_base;
        r_dest_x     <= n_dest_x;
        r_dest_y     <= n_dest_y;
        r_dest_index <= n_dest_index;
        r_pix_out    <= n_pix_out;
        r_last       <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_dest_x     = r_dest_x;
    assign o_dest_y     = r_dest_y;
    assign o_dest_index = r_dest_index;
    assign o_pixel_out  = r_pix_out;
    assign o_last_write = r_last;

endmodule
